// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the block clock, disabled while reset is low.
`define CSBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define CSBC_ASSERT_IMPL(label, pre, post, msg) \
  `CSBC_ASSERT(label, (pre) |-> (post), msg)

`endif

// ===== rtl/csbc_pkg.sv =====
// ----------------------------------------------------------------------------
// csbc_pkg
// Types and constants shared by the circle/square contact classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package csbc_pkg;

  // Width and reset value of the tolerance register.
  localparam int unsigned TOL_WIDTH = 8;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd1;

  // Relation codes reported on each result beat.
  typedef enum logic [1:0] {
    REL_DISJOINT   = 2'd0,
    REL_SQ_IN_CIRC = 2'd1,
    REL_CIRC_IN_SQ = 2'd2,
    REL_MEET       = 2'd3
  } relation_e;

  // Decision flags carried from the compare stage to the sum stage.
  typedef struct packed {
    logic x_low;    // center left of the square by more than tolerance
    logic x_high;   // center right of the square by more than tolerance
    logic y_low;    // center below the square by more than tolerance
    logic y_high;   // center above the square by more than tolerance
    logic circ_in;  // circle strictly inside the square with margin
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/csbc_square.sv =====
// ----------------------------------------------------------------------------
// csbc_square
// Registered unsigned squarer: one multiplier followed by its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csbc_square #(
  parameter int unsigned IN_WIDTH = 25
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [IN_WIDTH-1:0]     a_i,
  output logic      [2*IN_WIDTH-1:0]   sq_o
);

  logic [2*IN_WIDTH-1:0] sq_d;
  logic [2*IN_WIDTH-1:0] sq_q;

  // Full-width product of the operand with itself.
  assign sq_d = {{IN_WIDTH{1'b0}}, a_i} * {{IN_WIDTH{1'b0}}, a_i};

  // The product advances only with the pipeline.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ===== rtl/circle_square_boundary_contact.sv =====
// ----------------------------------------------------------------------------
// circle_square_boundary_contact
// Classifies a circle against an axis-aligned square using squared distances.
// ----------------------------------------------------------------------------
// The block takes one query beat per clock unless in_stall_o is high, and
// returns one result beat per query, in order. The four register stages are
// edge differences, the bank of six squarers, the squared-distance sums, and
// the final compares into the output register; the squarer stage sets the
// clock. A held result beat under stall freezes the whole pipeline and stalls
// the input in the same cycle. The tolerance register resets to one LSB. The
// user must write it only while the pipeline is empty; it is not enforced.
`default_nettype none

`include "assert_macros.svh"

module circle_square_boundary_contact
  import csbc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [TOL_WIDTH-1:0]        cfg_wdata_i,
  // Query channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] circle_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] circle_y_i,
  input  wire logic [COORD_WIDTH-2:0]      radius_i,
  input  wire logic signed [COORD_WIDTH-1:0] square_left_i,
  input  wire logic signed [COORD_WIDTH-1:0] square_top_i,
  input  wire logic [COORD_WIDTH-2:0]      side_length_i,
  // Result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       relation_o,
  output logic                             boundaries_meet_o
);

  localparam int unsigned DW = COORD_WIDTH + 2;  // signed difference width
  localparam int unsigned MW = COORD_WIDTH + 1;  // magnitude width
  localparam int unsigned QW = 2 * MW;           // square width
  localparam int unsigned SW = QW + 1;           // sum of two squares

  logic adv;

  logic [TOL_WIDTH-1:0] tol_q;

  // Stage 1 registers.
  logic                 v1_q;
  logic signed [DW-1:0] dxl_q, dxr_q, dyt_q, dyb_q;
  logic signed [DW-1:0] dxl_d, dxr_d, dyt_d, dyb_d;
  logic [MW-1:0]        rpe_q, rme_q, rpe_d, rme_d;
  logic [TOL_WIDTH-1:0] eps_q;

  // Stage 2 registers.
  logic                 v2_q;
  flags_t               flags2_q, flags2_d;
  logic [QW-1:0]        sq_xl, sq_xr, sq_yt, sq_yb, sq_rp, sq_rm;

  // Stage 3 registers.
  logic                 v3_q;
  logic                 circ_in3_q;
  logic [SW-1:0]        dist_q, c_lt_q, c_rt_q, c_rb_q, c_lb_q;
  logic [SW-1:0]        dist_d;
  logic [QW-1:0]        rp3_q, rm3_q;

  // Output registers.
  logic                 out_valid_q;
  relation_e            rel_q, rel_d;
  logic                 meet_q;

  // The whole pipeline moves unless a finished beat is held at the output.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Stage 1: square edges, center offsets and the two radius margins.
  always_comb begin
    logic signed [DW-1:0] cx, cy, lft, top, rgt, bot, side, eps_s, r_s, rme_s;
    cx    = DW'(circle_x_i);
    cy    = DW'(circle_y_i);
    lft   = DW'(square_left_i);
    top   = DW'(square_top_i);
    side  = $signed({3'b000, side_length_i});
    r_s   = $signed({3'b000, radius_i});
    eps_s = $signed({{(DW-TOL_WIDTH){1'b0}}, tol_q});
    rgt   = lft + side;
    bot   = top - side;
    dxl_d = cx - lft;
    dxr_d = rgt - cx;
    dyt_d = top - cy;
    dyb_d = cy - bot;
    rpe_d = MW'(r_s + eps_s);
    rme_s = r_s - eps_s;
    // A margin at or below zero can never hold a corner strictly inside.
    rme_d = (rme_s > 0) ? MW'(rme_s) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dxl_q <= dxl_d;
      dxr_q <= dxr_d;
      dyt_q <= dyt_d;
      dyb_q <= dyb_d;
      rpe_q <= rpe_d;
      rme_q <= rme_d;
      eps_q <= tol_q;
    end
  end

  // Stage 2: magnitudes into the squarer bank.
  logic [MW-1:0] mag_xl, mag_xr, mag_yt, mag_yb;

  always_comb begin
    mag_xl = dxl_q[DW-1] ? MW'(-dxl_q) : MW'(dxl_q);
    mag_xr = dxr_q[DW-1] ? MW'(-dxr_q) : MW'(dxr_q);
    mag_yt = dyt_q[DW-1] ? MW'(-dyt_q) : MW'(dyt_q);
    mag_yb = dyb_q[DW-1] ? MW'(-dyb_q) : MW'(dyb_q);
  end

  csbc_square #(.IN_WIDTH(MW)) u_sq_xl (
    .clk_i(clk_i), .en_i(adv), .a_i(mag_xl), .sq_o(sq_xl)
  );
  csbc_square #(.IN_WIDTH(MW)) u_sq_xr (
    .clk_i(clk_i), .en_i(adv), .a_i(mag_xr), .sq_o(sq_xr)
  );
  csbc_square #(.IN_WIDTH(MW)) u_sq_yt (
    .clk_i(clk_i), .en_i(adv), .a_i(mag_yt), .sq_o(sq_yt)
  );
  csbc_square #(.IN_WIDTH(MW)) u_sq_yb (
    .clk_i(clk_i), .en_i(adv), .a_i(mag_yb), .sq_o(sq_yb)
  );
  csbc_square #(.IN_WIDTH(MW)) u_sq_rp (
    .clk_i(clk_i), .en_i(adv), .a_i(rpe_q), .sq_o(sq_rp)
  );
  csbc_square #(.IN_WIDTH(MW)) u_sq_rm (
    .clk_i(clk_i), .en_i(adv), .a_i(rme_q), .sq_o(sq_rm)
  );

  // Stage 2: side tests with margin and the nearest-edge check.
  always_comb begin
    logic signed [DW-1:0] eps_s, m_x, m_y, m_all;
    logic                 center_in;
    eps_s          = $signed({{(DW-TOL_WIDTH){1'b0}}, eps_q});
    flags2_d.x_low  = dxl_q < -eps_s;
    flags2_d.x_high = dxr_q < -eps_s;
    flags2_d.y_low  = dyb_q < -eps_s;
    flags2_d.y_high = dyt_q < -eps_s;
    center_in = (dxl_q > eps_s) && (dxr_q > eps_s) && (dyb_q > eps_s) && (dyt_q > eps_s);
    m_x    = (dxr_q < dxl_q) ? dxr_q : dxl_q;
    m_y    = (dyb_q < dyt_q) ? dyb_q : dyt_q;
    m_all  = (m_y < m_x) ? m_y : m_x;
    flags2_d.circ_in = center_in && ($signed({1'b0, rpe_q}) < m_all);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flags2_q <= flags2_d;
    end
  end

  // Stage 3: clamped center distance and the four corner distances.
  always_comb begin
    logic [QW-1:0] dx2, dy2;
    if (flags2_q.x_low) begin
      dx2 = sq_xl;
    end else if (flags2_q.x_high) begin
      dx2 = sq_xr;
    end else begin
      dx2 = '0;
    end
    if (flags2_q.y_low) begin
      dy2 = sq_yb;
    end else if (flags2_q.y_high) begin
      dy2 = sq_yt;
    end else begin
      dy2 = '0;
    end
    dist_d = {1'b0, dx2} + {1'b0, dy2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q     <= dist_d;
      c_lt_q     <= {1'b0, sq_xl} + {1'b0, sq_yt};
      c_rt_q     <= {1'b0, sq_xr} + {1'b0, sq_yt};
      c_rb_q     <= {1'b0, sq_xr} + {1'b0, sq_yb};
      c_lb_q     <= {1'b0, sq_xl} + {1'b0, sq_yb};
      rp3_q      <= sq_rp;
      rm3_q      <= sq_rm;
      circ_in3_q <= flags2_q.circ_in;
    end
  end

  // Stage 4: relation in priority order.
  always_comb begin
    logic [SW-1:0] rm_ext;
    logic          sq_in;
    rm_ext = {1'b0, rm3_q};
    sq_in  = (c_lt_q < rm_ext) && (c_rt_q < rm_ext) &&
             (c_rb_q < rm_ext) && (c_lb_q < rm_ext);
    if (dist_q > {1'b0, rp3_q}) begin
      rel_d = REL_DISJOINT;
    end else if (sq_in) begin
      rel_d = REL_SQ_IN_CIRC;
    end else if (circ_in3_q) begin
      rel_d = REL_CIRC_IN_SQ;
    end else begin
      rel_d = REL_MEET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rel_q  <= rel_d;
      meet_q <= (rel_d == REL_MEET);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign relation_o        = rel_q;
  assign boundaries_meet_o = meet_q;

  // A held result beat must freeze the query side in the same cycle.
  `CSBC_ASSERT_IMPL(a_hold_stalls_input, out_valid_o && out_stall_i, in_stall_o,
                    "input not stalled while result beat is held")
  // A new result beat only appears from an occupied stage three.
  `CSBC_ASSERT_IMPL(a_out_from_stage3, $rose(out_valid_o), $past(v3_q),
                    "result beat appeared without a beat in stage three")
  // The meet flag agrees with the relation code.
  `CSBC_ASSERT_IMPL(a_meet_matches, out_valid_o,
                    boundaries_meet_o == (relation_o == REL_MEET),
                    "boundaries_meet disagrees with relation")

endmodule

`default_nettype wire
